FILE: sv/crs_pkg.sv
`timescale 1ns / 1ps

package crs_pkg;

   localparam int STEP_LIMIT       = 10000;
   localparam int MAX_MODULUS_BITS = 32;
   localparam int MIN_MODULUS_BITS = 4;

   localparam int RESIDUE_W    = 32;
   localparam int CFG_W        = 6;
   localparam int COUNT_W      = 6;
   localparam int MULT_W       = 51;
   localparam int TERM_W       = 64;
   localparam int DROP_STEPS_W = 14;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [CFG_W-1:0] MODULUS_BITS_RESET   = 6'd16;
   localparam logic [CFG_W-1:0] DEAD_THRESHOLD_RESET = 6'd10;

   typedef enum logic {
      REG_MODULUS_BITS   = 1'b0,
      REG_DEAD_THRESHOLD = 1'b1
   } reg_index_type;

endpackage

FILE: sv/collatz_residue_sieve.sv
`timescale 1ns / 1ps

// collatz residue sieve: takes one residue r per request and returns one result
// request channel: req_valid / req_ready with req_residue
// result channel: rsp_valid / rsp_ready with the class walk and exact walk results
// csr: apb-style writes to modulus_bits (0x0) and dead_threshold (0x4), pready tied high
// the class walk does one parity step per cycle over the low k bits, then moves on to
// the exact walk
// the exact walk then does one collatz step per cycle on r: s steps, at most STEP_LIMIT,
// ending early at the first value below r
// the result register is then loaded once it is free; rsp_valid rises as the block goes
// back to idle, so the next request can be taken while that result waits; one request
// is in work at a time
// req_ready is high only while idle; a new request may start while the last result
// still waits in the output register
// if the receiver stalls and a second result is ready, the walk holds until the first
// result is taken
// reset is synchronous: the block goes idle, rsp_valid drops and both csrs take their
// reset values (k = 16, threshold = 10)
module collatz_residue_sieve #(
   parameter int STEP_LIMIT       = crs_pkg::STEP_LIMIT,
   parameter int MAX_MODULUS_BITS = crs_pkg::MAX_MODULUS_BITS
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [crs_pkg::RESIDUE_W-1:0]       req_residue,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [crs_pkg::COUNT_W-1:0]         rsp_odd_step_count,
   output logic                                rsp_class_is_dead,
   output logic [crs_pkg::MULT_W-1:0]          rsp_multiplier,
   output logic [crs_pkg::TERM_W-1:0]          rsp_additive_term,
   output logic                                rsp_drops_below,
   output logic [crs_pkg::DROP_STEPS_W-1:0]    rsp_drop_steps,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [crs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [crs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [crs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int MAXB = MAX_MODULUS_BITS;
   localparam int KW   = $clog2(MAXB + 1);
   localparam int IW   = (MAXB > 1) ? $clog2(MAXB) : 1;
   localparam int SW   = $clog2(STEP_LIMIT + 1);
   localparam int RW   = crs_pkg::RESIDUE_W;
   localparam int TW   = crs_pkg::TERM_W;
   localparam int MW   = crs_pkg::MULT_W;
   localparam int CW   = crs_pkg::CFG_W;
   localparam int DW   = crs_pkg::DROP_STEPS_W;
   localparam int SXW  = (SW > DW) ? SW : DW;

   localparam logic [SW-1:0] LIMIT = SW'(STEP_LIMIT);
   localparam logic [KW-1:0] K_MAX = KW'(MAXB);
   localparam logic [KW-1:0] K_MIN = KW'(crs_pkg::MIN_MODULUS_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASS,
      ST_EXACT
   } state_type;

   // csr
   logic [CW-1:0] modulus_bits_ff, modulus_bits_in;
   logic [CW-1:0] dead_threshold_ff, dead_threshold_in;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      modulus_bits_in   = modulus_bits_ff;
      dead_threshold_in = dead_threshold_ff;
      if (csr_write) begin
         case (crs_pkg::reg_index_type'(paddr[2]))
            crs_pkg::REG_MODULUS_BITS:   modulus_bits_in   = pwdata[CW-1:0];
            crs_pkg::REG_DEAD_THRESHOLD: dead_threshold_in = pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (crs_pkg::reg_index_type'(paddr[2]))
         crs_pkg::REG_MODULUS_BITS:
            prdata = {{(crs_pkg::CSR_DATA_W-CW){1'b0}}, modulus_bits_ff};
         crs_pkg::REG_DEAD_THRESHOLD:
            prdata = {{(crs_pkg::CSR_DATA_W-CW){1'b0}}, dead_threshold_ff};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_bits_ff   <= crs_pkg::MODULUS_BITS_RESET;
         dead_threshold_ff <= crs_pkg::DEAD_THRESHOLD_RESET;
      end else begin
         modulus_bits_ff   <= modulus_bits_in;
         dead_threshold_ff <= dead_threshold_in;
      end
   end

   // effective modulus width
   logic [KW-1:0] k_eff;

   always_comb begin
      if (modulus_bits_ff < CW'(crs_pkg::MIN_MODULUS_BITS)) begin
         k_eff = K_MIN;
      end else if (modulus_bits_ff > CW'(MAXB)) begin
         k_eff = K_MAX;
      end else begin
         k_eff = KW'(modulus_bits_ff);
      end
   end

   // walk state
   state_type         state_ff, state_in;
   logic [RW-1:0]     residue_ff, residue_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [MAXB-1:0]   mask_ff, mask_in;
   logic [MAXB-1:0]   x_ff, x_in;
   logic [KW-1:0]     b_ff, b_in;
   logic [CW-1:0]     a_ff, a_in;
   logic [MW-1:0]     mul_ff, mul_in;
   logic [TW-1:0]     add_ff, add_in;
   logic [TW-1:0]     v_ff, v_in;
   logic [SW-1:0]     steps_ff, steps_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     out_count_ff, out_count_in;
   logic              out_dead_ff, out_dead_in;
   logic [MW-1:0]     out_mul_ff, out_mul_in;
   logic [TW-1:0]     out_add_ff, out_add_in;
   logic              out_drop_ff, out_drop_in;
   logic [DW-1:0]     out_steps_ff, out_steps_in;

   // step unit signals
   logic [MAXB-1:0]   new_mask;
   logic [MAXB-1:0]   bit_val;
   logic              x_bit;
   logic [MAXB+1:0]   x_sum;
   logic [TW-1:0]     v_step;
   logic              v_below;
   logic              can_load;
   logic [SXW-1:0]    steps_ext;

   assign new_mask  = ~({MAXB{1'b1}} << k_eff);
   assign bit_val   = {{(MAXB-1){1'b0}}, 1'b1} << b_ff[IW-1:0];
   assign x_bit     = x_ff[b_ff[IW-1:0]];
   assign x_sum     = {2'b00, x_ff} + {1'b0, x_ff, 1'b0} + {2'b00, bit_val};
   assign v_step    = v_ff[0] ? ((v_ff << 1) + v_ff + TW'(1)) : (v_ff >> 1);
   assign v_below   = v_ff < {{(TW-RW){1'b0}}, residue_ff};
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign steps_ext = SXW'(steps_ff);

   always_comb begin
      state_in     = state_ff;
      residue_in   = residue_ff;
      k_in         = k_ff;
      mask_in      = mask_ff;
      x_in         = x_ff;
      b_in         = b_ff;
      a_in         = a_ff;
      mul_in       = mul_ff;
      add_in       = add_ff;
      v_in         = v_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_count_in = out_count_ff;
      out_dead_in  = out_dead_ff;
      out_mul_in   = out_mul_ff;
      out_add_in   = out_add_ff;
      out_drop_in  = out_drop_ff;
      out_steps_in = out_steps_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               residue_in = req_residue;
               k_in       = k_eff;
               mask_in    = new_mask;
               x_in       = req_residue[MAXB-1:0] & new_mask;
               b_in       = '0;
               a_in       = '0;
               mul_in     = MW'(1);
               add_in     = '0;
               state_in   = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (b_ff < k_ff) begin
               if (x_bit) begin
                  x_in   = x_sum[MAXB-1:0] & mask_ff;
                  mul_in = (mul_ff << 1) + mul_ff;
                  add_in = (add_ff << 1) + add_ff + TW'(bit_val);
                  a_in   = a_ff + CW'(1);
               end else begin
                  b_in = b_ff + KW'(1);
               end
            end else begin
               v_in     = {{(TW-RW){1'b0}}, residue_ff};
               steps_in = '0;
               state_in = ST_EXACT;
            end
         end
         ST_EXACT: begin
            if (v_below || steps_ff == LIMIT) begin
               if (can_load) begin
                  rsp_valid_in = 1'b1;
                  out_count_in = a_ff;
                  out_dead_in  = a_ff <= dead_threshold_ff;
                  out_mul_in   = mul_ff;
                  out_add_in   = add_ff;
                  out_drop_in  = v_below;
                  out_steps_in = v_below ? steps_ext[DW-1:0] : '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               v_in     = v_step;
               steps_in = steps_ff + SW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      residue_ff   <= residue_in;
      k_ff         <= k_in;
      mask_ff      <= mask_in;
      x_ff         <= x_in;
      b_ff         <= b_in;
      a_ff         <= a_in;
      mul_ff       <= mul_in;
      add_ff       <= add_in;
      v_ff         <= v_in;
      steps_ff     <= steps_in;
      out_count_ff <= out_count_in;
      out_dead_ff  <= out_dead_in;
      out_mul_ff   <= out_mul_in;
      out_add_ff   <= out_add_in;
      out_drop_ff  <= out_drop_in;
      out_steps_ff <= out_steps_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_odd_step_count = out_count_ff;
   assign rsp_class_is_dead  = out_dead_ff;
   assign rsp_multiplier     = out_mul_ff;
   assign rsp_additive_term  = out_add_ff;
   assign rsp_drops_below    = out_drop_ff;
   assign rsp_drop_steps     = out_steps_ff;

endmodule
